/* sv/cpam_pkg.sv */
// Shared types and constants for the correlator pair address map.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package cpam_pkg;

    localparam int unsigned InWidth     = 10;
    localparam int unsigned CountWidth  = 10;
    localparam int unsigned TileWidth   = 20;
    localparam int unsigned PackedWidth = 21;
    localparam int unsigned CellWidth   = 18;

    localparam logic [CountWidth-1:0] CountReset = 10'd512;

    // Part of the packed buffer that a station pair falls into.
    typedef enum logic [1:0] {
        REGION_TOP,
        REGION_MID,
        REGION_BOT
    } cpam_region_t;

    // After decode: station halves, polarisations, effective count, check.
    typedef struct packed {
        logic [8:0] a0;
        logic [8:0] a1;
        logic       p0;
        logic       p1;
        logic [9:0] stations;
        logic       ok;
    } cpam_decode_t;

    // After the multiplier stage.
    typedef struct packed {
        logic [16:0]  tile_tri_prod;
        logic [7:0]   tile_col;
        logic [1:0]   quad;
        logic [19:0]  quad_prod;
        logic [18:0]  tri_size_prod;
        logic [19:0]  packed_prod;
        logic [8:0]   packed_col;
        logic [8:0]   half;
        cpam_region_t region;
        logic         p0;
        logic         p1;
        logic         ok;
    } cpam_product_t;

    // After the cell index sums.
    typedef struct packed {
        logic [CellWidth-1:0] tile_cell;
        logic [CellWidth-1:0] packed_cell;
        logic                 p0;
        logic                 p1;
        logic                 ok;
    } cpam_cell_t;

endpackage

`default_nettype wire

/* sv/cpam_cfg_if.sv */
// Configuration write channel: station count word.
// Depends on cpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cpam_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cpam_pkg::CountWidth-1:0]   station_count;

    modport source (output valid, output station_count, input ready);
    modport sink   (input valid, input station_count, output ready);
endinterface

`default_nettype wire

/* sv/cpam_pair_if.sv */
// Input channel: one pair of correlator input numbers per word.
// Depends on cpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cpam_pair_if;
    logic                           valid;
    logic                           ready;
    logic [cpam_pkg::InWidth-1:0]   first_input;
    logic [cpam_pkg::InWidth-1:0]   second_input;

    modport source (output valid, output first_input, output second_input, input ready);
    modport sink   (input valid, input first_input, input second_input, output ready);
endinterface

`default_nettype wire

/* sv/cpam_addr_if.sv */
// Output channel: tile and packed word addresses plus valid flag.
// Depends on cpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cpam_addr_if;
    logic                               valid;
    logic                               ready;
    logic [cpam_pkg::TileWidth-1:0]     tile_word_address;
    logic [cpam_pkg::PackedWidth-1:0]   packed_word_address;
    logic                               pair_valid;

    modport source (output valid, output tile_word_address, output packed_word_address,
                    output pair_valid, input ready);
    modport sink   (input valid, input tile_word_address, input packed_word_address,
                    input pair_valid, output ready);
endinterface

`default_nettype wire

/* sv/cpam_decode.sv */
// Stage 1: station count clamp, pair order and range check, field split.
// Depends on cpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpam_decode #(
    parameter int unsigned MAX_STATIONS = 512
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [cpam_pkg::CountWidth-1:0]   station_count,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic [cpam_pkg::InWidth-1:0]      first_input,
    input  wire logic [cpam_pkg::InWidth-1:0]      second_input,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      cpam_pkg::cpam_decode_t            out_data
);
    import cpam_pkg::*;

    localparam logic [11:0] MaxRounded = 12'((MAX_STATIONS / 4) * 4);

    logic [CountWidth-1:0] count_floor;
    logic [CountWidth-1:0] stations;
    cpam_decode_t          data_next;
    cpam_decode_t          data_reg;
    logic                  valid_reg;

    always_comb
    begin
        count_floor = {station_count[CountWidth-1:2], 2'b00};
        stations    = ({2'b00, count_floor} > MaxRounded) ? MaxRounded[CountWidth-1:0]
                                                          : count_floor;
        data_next.a0       = first_input[InWidth-1:1];
        data_next.a1       = second_input[InWidth-1:1];
        data_next.p0       = first_input[0];
        data_next.p1       = second_input[0];
        data_next.stations = stations;
        data_next.ok       = (first_input <= second_input) &&
                             ({1'b0, second_input} < {stations, 1'b0});
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cpam_product.sv */
// Stage 2: region choice and the four narrow products of the cell indices.
// Depends on cpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpam_product (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire cpam_pkg::cpam_decode_t    in_data,
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      cpam_pkg::cpam_product_t   out_data
);
    import cpam_pkg::*;

    logic [8:0]    half;
    logic [9:0]    half_inc;
    logic [8:0]    delta;
    logic [8:0]    bot_row;
    logic [9:0]    bot_col;
    logic [8:0]    mid_col;
    logic [7:0]    tile_row;
    logic [8:0]    tile_row_inc;
    logic [9:0]    op_a;
    logic [9:0]    op_b;
    cpam_region_t  region;
    cpam_product_t data_next;
    cpam_product_t data_reg;
    logic          valid_reg;

    always_comb
    begin
        half         = in_data.stations[9:1];
        half_inc     = {1'b0, half} + 10'd1;
        delta        = in_data.a1 - in_data.a0;
        bot_row      = half - 9'd2 - in_data.a0;
        bot_col      = in_data.stations - 10'd1 - {1'b0, in_data.a1};
        mid_col      = half - delta;
        tile_row     = in_data.a1[8:1];
        tile_row_inc = {1'b0, tile_row} + 9'd1;

        if (delta > half)
        begin
            region = REGION_BOT;
        end
        else if (in_data.a1 < half)
        begin
            region = REGION_TOP;
        end
        else
        begin
            region = REGION_MID;
        end

        // one shared multiplier for the packed cell, operands by region
        case (region)
            REGION_BOT:
            begin
                op_a                 = {1'b0, bot_row};
                op_b                 = {1'b0, bot_row} + 10'd1;
                data_next.packed_col = bot_col[8:0];
            end
            REGION_TOP:
            begin
                op_a                 = {1'b0, in_data.a1};
                op_b                 = {1'b0, in_data.a1} + 10'd1;
                data_next.packed_col = in_data.a0;
            end
            default:
            begin
                op_a                 = {1'b0, in_data.a1 - half};
                op_b                 = half_inc;
                data_next.packed_col = mid_col;
            end
        endcase

        data_next.tile_tri_prod = 17'(tile_row) * 17'(tile_row_inc);
        data_next.tile_col      = in_data.a0[8:1];
        data_next.quad          = {in_data.a0[0], in_data.a1[0]};
        data_next.quad_prod     = 20'(half_inc) * 20'(in_data.stations);
        data_next.tri_size_prod = 19'(half_inc) * 19'(half);
        data_next.packed_prod   = 20'(op_a) * 20'(op_b);
        data_next.half          = half;
        data_next.region        = region;
        data_next.p0            = in_data.p0;
        data_next.p1            = in_data.p1;
        data_next.ok            = in_data.ok;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cpam_cell.sv */
// Stage 3: sums that form the tile and packed cell indices.
// Depends on cpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpam_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire cpam_pkg::cpam_product_t   in_data,
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      cpam_pkg::cpam_cell_t      out_data
);
    import cpam_pkg::*;

    logic [CellWidth-1:0] quad_size;
    logic [CellWidth-1:0] quad_term;
    logic [CellWidth-1:0] tri_size;
    logic [CellWidth-1:0] packed_tri;
    cpam_cell_t           data_next;
    cpam_cell_t           data_reg;
    logic                 valid_reg;

    always_comb
    begin
        quad_size  = in_data.quad_prod[19:2];
        tri_size   = in_data.tri_size_prod[18:1];
        packed_tri = in_data.packed_prod[18:1];

        // quadrant times quadrant size, shift and add
        case (in_data.quad)
            2'd0:    quad_term = '0;
            2'd1:    quad_term = quad_size;
            2'd2:    quad_term = {quad_size[CellWidth-2:0], 1'b0};
            default: quad_term = quad_size + {quad_size[CellWidth-2:0], 1'b0};
        endcase

        data_next.tile_cell = quad_term + 18'(in_data.tile_tri_prod[16:1])
                            + 18'(in_data.tile_col);

        case (in_data.region)
            REGION_TOP:
            begin
                data_next.packed_cell = packed_tri + 18'(in_data.packed_col);
            end
            REGION_MID:
            begin
                data_next.packed_cell = tri_size + in_data.packed_prod[CellWidth-1:0]
                                      + 18'(in_data.packed_col);
            end
            default:
            begin
                // counted back from the last cell of the buffer
                data_next.packed_cell = {tri_size[CellWidth-3:0], 2'b00}
                                      - 18'(in_data.half) - 18'd1 - packed_tri
                                      - 18'(in_data.packed_col);
            end
        endcase

        data_next.p0 = in_data.p0;
        data_next.p1 = in_data.p1;
        data_next.ok = in_data.ok;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* sv/correlator_pair_address_map.sv */
// Top level of the correlator pair address map: config register, stage chain, output register.
// Depends on cpam_pkg, cpam_*_if, cpam_decode, cpam_product, cpam_cell.
//
//  channel    dir  payload                                            word per cycle
//  ---------  ---  -------------------------------------------------  --------------
//  cfg        in   station_count (10 b)                               always ready
//  pairs      in   first_input, second_input (10 b each)              1
//  addresses  out  tile_word_address (20 b), packed_word_address      1
//                  (21 b), pair_valid
//
// One word per cycle while addresses is ready; each word passes the stages below in order.
// Stages: decode and check, products (shared packed multiplier), cell sums, output register.
// Each stage advances when it is empty or the stage after it moves, so a stall
// on addresses backs up stage by stage; no word is dropped or repeated.
// Reset clears the stage valid bits and loads station_count with 512.
`timescale 1ns / 1ps
`default_nettype none

module correlator_pair_address_map #(
    parameter int unsigned MAX_STATIONS = 512
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpam_cfg_if.sink   cfg,
    cpam_pair_if.sink  pairs,
    cpam_addr_if.source addresses
);
    import cpam_pkg::*;

    logic [CountWidth-1:0]  count_reg;

    logic                   dec_valid;
    logic                   dec_ready;
    cpam_decode_t           dec_data;
    logic                   prod_valid;
    logic                   prod_ready;
    cpam_product_t          prod_data;
    logic                   cell_valid;
    logic                   cell_ready;
    cpam_cell_t             cell_data;

    logic                   out_valid_reg;
    logic [TileWidth-1:0]   tile_reg;
    logic [TileWidth-1:0]   tile_next;
    logic [PackedWidth-1:0] packed_reg;
    logic [PackedWidth-1:0] packed_next;
    logic                   pair_valid_reg;

    // configuration: one register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CountReset;
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.station_count;
        end
    end

    cpam_decode #(
        .MAX_STATIONS (MAX_STATIONS)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .station_count (count_reg),
        .in_valid      (pairs.valid),
        .in_ready      (pairs.ready),
        .first_input   (pairs.first_input),
        .second_input  (pairs.second_input),
        .out_valid     (dec_valid),
        .out_ready     (dec_ready),
        .out_data      (dec_data)
    );

    cpam_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    cpam_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (cell_valid),
        .out_ready (cell_ready),
        .out_data  (cell_data)
    );

    // output stage: word address = cell * 4 + polarisation offset (tile),
    // cell * 8 + 2 * (2 * (p0 ^ p1) + p0) (packed); zeros when the pair is rejected
    always_comb
    begin
        if (cell_data.ok)
        begin
            tile_next   = {cell_data.tile_cell, cell_data.p1, cell_data.p0};
            packed_next = {cell_data.packed_cell, cell_data.p0 ^ cell_data.p1,
                           cell_data.p0, 1'b0};
        end
        else
        begin
            tile_next   = '0;
            packed_next = '0;
        end
    end

    assign cell_ready = !out_valid_reg || addresses.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cell_ready)
        begin
            out_valid_reg <= cell_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_ready && cell_valid)
        begin
            tile_reg       <= tile_next;
            packed_reg     <= packed_next;
            pair_valid_reg <= cell_data.ok;
        end
    end

    assign addresses.valid               = out_valid_reg;
    assign addresses.tile_word_address   = tile_reg;
    assign addresses.packed_word_address = packed_reg;
    assign addresses.pair_valid          = pair_valid_reg;

`ifndef SYNTH
    // a rejected pair carries zero addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pair_valid_reg |-> tile_reg == '0 && packed_reg == '0)
        else $error("rejected pair with non-zero address");

    // an empty output register means the whole chain can take a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pairs.ready)
        else $error("input stalled with empty output stage");

    // a word waiting in the cell stage is kept while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_ready |=> cell_valid && $stable(cell_data))
        else $error("cell stage word lost under stall");

    // station count only changes on a configuration write
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.valid |=> $stable(count_reg))
        else $error("station count changed without a write");
`endif

endmodule

`default_nettype wire
